/* rtl/wbs_pkg.sv */
`default_nettype none

package wbs_pkg;

    localparam logic [63:0] K0 = 64'ha0761d6478bd642f;
    localparam logic [63:0] K1 = 64'he7037ed1a0b428db;
    localparam logic [63:0] K2 = 64'h8ebc6af09c88c6e3;
    localparam logic [63:0] K3 = 64'h589965cc75374cc3;

    localparam int unsigned WIDE_CHUNK   = 48;
    localparam int unsigned NARROW_CHUNK = 16;

    // top-level sequencer
    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH_X,
        S_FETCH_Y,
        S_MUL_GO,
        S_MUL_WAIT,
        S_FIN,
        S_LOOP
    } state_t;

    // what the current fetch / multiply is for
    typedef enum logic [2:0] {
        JOB_WIDE,
        JOB_LONG,
        JOB_TAIL,
        JOB_SHORT4,
        JOB_SHORT1,
        JOB_FINAL,
        JOB_HASH
    } job_t;

endpackage

`default_nettype wire

/* rtl/wyhash_byte_stream_top.sv */
`default_nettype none

// 64-bit wyhash over a byte-serial message. Assert start with one byte
// (byte_present=1) or an empty end marker (byte_present=0, end_of_message=1);
// the transaction is taken when busy is low. An ordinary byte leaves busy low.
// Every 49th pending byte starts a wide absorb of 48 bytes: three lane folds,
// each two 8-byte gathers from the 64-byte ring at one byte per cycle, then
// a launch and a run of the shared 4-step multiplier, with busy held high
// throughout. The end of a message runs the lane merge after a wide absorb,
// up to two 16-byte folds, the tail reads and two more multiplies; a message
// of up to 16 bytes with no wide absorb has short reads in place of folds and
// tail, and an empty one neither. The end follows the wide absorb when the last
// byte starts one. The hash
// appears on hash_value with done high for exactly one cycle; the receiver
// cannot stall it, so it must capture the transaction in that cycle. Write
// hash_seed with seed_we only while busy is low; a new seed takes effect at
// the first byte of the next message. The byte ring is not cleared at reset.
module wyhash_byte_stream_top
    import wbs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [7:0]  data_byte,
    input  wire logic        byte_present,
    input  wire logic        end_of_message,
    input  wire logic        seed_we,
    input  wire logic [63:0] hash_seed,
    output logic             done,
    output logic [63:0]      hash_value
);

    // byte ring, indexed by byte position mod 64
    logic [7:0]  ring_mem [64];
    logic [7:0]  rdata_reg;
    logic [5:0]  rd_addr;

    state_t      state_reg, state_next;
    job_t        job_reg, job_next;
    logic [1:0]  lane_idx_reg, lane_idx_next;
    logic [3:0]  fcnt_reg, fcnt_next;
    logic        rd_valid_reg, rd_valid_next;
    logic [63:0] total_reg, total_next;
    logic [6:0]  pending_reg, pending_next;
    logic        wide_reg, wide_next;
    logic        last_reg, last_next;
    logic [63:0] seed_reg, seed_next;
    logic [63:0] lane0_reg, lane0_next;
    logic [63:0] lane1_reg, lane1_next;
    logic [63:0] lane2_reg, lane2_next;
    logic        done_reg, done_next;

    logic [63:0] xop_reg, xop_next;
    logic [63:0] yop_reg, yop_next;
    logic [63:0] word_reg, word_next;
    logic [63:0] hash_reg, hash_next;

    logic        accept;
    logic        issue;
    logic        fetch_done;
    logic [3:0]  fetch_n;
    logic [63:0] fetched;

    logic        mul_start;
    logic [63:0] mul_x, mul_y;
    logic        mul_done;
    logic [63:0] mul_result;

    logic [5:0]  len6, k6, yoff, off6, k2;
    logic        short_msg;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);

    wbs_fold_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .x      (mul_x),
        .y      (mul_y),
        .done   (mul_done),
        .result (mul_result)
    );

    // ---------------- byte gather ----------------
    assign len6 = total_reg[5:0];
    assign k6   = {3'd0, fcnt_reg[2:0]};
    assign k2   = {4'd0, fcnt_reg[1:0]};
    assign yoff = (state_reg == S_FETCH_Y) ? 6'd8 : 6'd0;
    assign off6 = {2'd0, len6[4:3], 2'd0};

    always_comb
    begin
        case (job_reg)
            JOB_WIDE:   rd_addr = len6 - 6'd49 + {lane_idx_reg, 4'd0} + yoff + k6;
            JOB_LONG:   rd_addr = len6 - pending_reg[5:0] + yoff + k6;
            JOB_TAIL:   rd_addr = len6 - 6'd16 + yoff + k6;
            JOB_SHORT4:
            begin
                if (state_reg == S_FETCH_Y)
                    rd_addr = fcnt_reg[2] ? (len6 - 6'd4 + k2) : (len6 - 6'd4 - off6 + k2);
                else
                    rd_addr = fcnt_reg[2] ? k2 : (off6 + k2);
            end
            JOB_SHORT1:
            begin
                case (fcnt_reg[1:0])
                    2'd0:    rd_addr = len6 - 6'd1;
                    2'd1:    rd_addr = {1'b0, len6[5:1]};
                    default: rd_addr = 6'd0;
                endcase
            end
            default:    rd_addr = 6'd0;
        endcase
    end

    assign fetch_n    = (job_reg == JOB_SHORT1) ? 4'd3 : 4'd8;
    assign issue      = ((state_reg == S_FETCH_X) || (state_reg == S_FETCH_Y))
                        && (fcnt_reg != fetch_n);
    assign fetch_done = ((state_reg == S_FETCH_X) || (state_reg == S_FETCH_Y))
                        && (fcnt_reg == fetch_n);
    assign word_next  = rd_valid_reg ? {rdata_reg, word_reg[63:8]} : word_reg;
    // bytes enter at the top; a 3-byte gather lands in [63:40]
    assign fetched    = (job_reg == JOB_SHORT1) ? (word_next >> 40) : word_next;

    assign short_msg  = !wide_reg && (total_reg <= 64'd16);

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next    = state_reg;
        job_next      = job_reg;
        lane_idx_next = lane_idx_reg;
        fcnt_next     = fcnt_reg;
        rd_valid_next = issue;
        total_next    = total_reg;
        pending_next  = pending_reg;
        wide_next     = wide_reg;
        last_next     = last_reg;
        seed_next     = seed_we ? hash_seed : seed_reg;
        lane0_next    = lane0_reg;
        lane1_next    = lane1_reg;
        lane2_next    = lane2_reg;
        done_next     = 1'b0;
        xop_next      = xop_reg;
        yop_next      = yop_reg;
        hash_next     = hash_reg;
        mul_start     = 1'b0;
        mul_x         = xop_reg ^ K1;
        mul_y         = yop_reg ^ lane0_reg;

        if (issue)
            fcnt_next = fcnt_reg + 4'd1;

        case (state_reg)
            S_IDLE:
            begin
                if (accept && (byte_present || end_of_message))
                begin
                    last_next = end_of_message;
                    if ((total_reg == 64'd0) && (pending_reg == 7'd0) && !wide_reg)
                    begin
                        lane0_next = seed_reg ^ K0;
                        lane1_next = seed_reg ^ K0;
                        lane2_next = seed_reg ^ K0;
                    end
                    if (byte_present)
                    begin
                        total_next   = total_reg + 64'd1;
                        pending_next = pending_reg + 7'd1;
                    end
                    if (byte_present && (pending_reg == 7'(WIDE_CHUNK)))
                    begin
                        job_next      = JOB_WIDE;
                        lane_idx_next = 2'd0;
                        state_next    = S_FETCH_X;
                    end
                    else if (end_of_message)
                        state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                if (short_msg)
                begin
                    if (total_reg >= 64'd4)
                    begin
                        job_next   = JOB_SHORT4;
                        state_next = S_FETCH_X;
                    end
                    else if (total_reg != 64'd0)
                    begin
                        job_next   = JOB_SHORT1;
                        state_next = S_FETCH_X;
                    end
                    else
                    begin
                        xop_next   = 64'd0;
                        yop_next   = 64'd0;
                        job_next   = JOB_FINAL;
                        state_next = S_MUL_GO;
                    end
                end
                else
                begin
                    if (wide_reg)
                        lane0_next = lane0_reg ^ lane1_reg ^ lane2_reg;
                    state_next = S_LOOP;
                end
            end

            S_LOOP:
            begin
                job_next   = (pending_reg > 7'(NARROW_CHUNK)) ? JOB_LONG : JOB_TAIL;
                state_next = S_FETCH_X;
            end

            S_FETCH_X:
            begin
                if (fetch_done)
                begin
                    fcnt_next = 4'd0;
                    xop_next  = fetched;
                    if (job_reg == JOB_SHORT1)
                    begin
                        yop_next   = 64'd0;
                        job_next   = JOB_FINAL;
                        state_next = S_MUL_GO;
                    end
                    else
                        state_next = S_FETCH_Y;
                end
            end

            S_FETCH_Y:
            begin
                if (fetch_done)
                begin
                    fcnt_next  = 4'd0;
                    yop_next   = fetched;
                    state_next = S_MUL_GO;
                    if ((job_reg == JOB_TAIL) || (job_reg == JOB_SHORT4))
                        job_next = JOB_FINAL;
                end
            end

            S_MUL_GO:
            begin
                mul_start  = 1'b1;
                state_next = S_MUL_WAIT;
                case (job_reg)
                    JOB_WIDE:
                    begin
                        case (lane_idx_reg)
                            2'd0:
                            begin
                                mul_x = xop_reg ^ K1;
                                mul_y = yop_reg ^ lane0_reg;
                            end
                            2'd1:
                            begin
                                mul_x = xop_reg ^ K2;
                                mul_y = yop_reg ^ lane1_reg;
                            end
                            default:
                            begin
                                mul_x = xop_reg ^ K3;
                                mul_y = yop_reg ^ lane2_reg;
                            end
                        endcase
                    end
                    JOB_HASH:
                    begin
                        mul_x = K1 ^ total_reg;
                        mul_y = yop_reg;
                    end
                    default:
                    begin
                        mul_x = xop_reg ^ K1;
                        mul_y = yop_reg ^ lane0_reg;
                    end
                endcase
            end

            S_MUL_WAIT:
            begin
                if (mul_done)
                begin
                    case (job_reg)
                        JOB_WIDE:
                        begin
                            case (lane_idx_reg)
                                2'd0:    lane0_next = mul_result;
                                2'd1:    lane1_next = mul_result;
                                default: lane2_next = mul_result;
                            endcase
                            if (lane_idx_reg == 2'd2)
                            begin
                                lane_idx_next = 2'd0;
                                pending_next  = pending_reg - 7'(WIDE_CHUNK);
                                wide_next     = 1'b1;
                                state_next    = last_reg ? S_FIN : S_IDLE;
                            end
                            else
                            begin
                                lane_idx_next = lane_idx_reg + 2'd1;
                                state_next    = S_FETCH_X;
                            end
                        end
                        JOB_LONG:
                        begin
                            lane0_next   = mul_result;
                            pending_next = pending_reg - 7'(NARROW_CHUNK);
                            state_next   = S_LOOP;
                        end
                        JOB_FINAL:
                        begin
                            yop_next   = mul_result;
                            job_next   = JOB_HASH;
                            state_next = S_MUL_GO;
                        end
                        default:
                        begin
                            // final hash out; message state back to start
                            hash_next    = mul_result;
                            done_next    = 1'b1;
                            total_next   = 64'd0;
                            pending_next = 7'd0;
                            wide_next    = 1'b0;
                            lane0_next   = seed_reg ^ K0;
                            lane1_next   = seed_reg ^ K0;
                            lane2_next   = seed_reg ^ K0;
                            state_next   = S_IDLE;
                        end
                    endcase
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            job_reg      <= JOB_WIDE;
            lane_idx_reg <= 2'd0;
            fcnt_reg     <= 4'd0;
            rd_valid_reg <= 1'b0;
            total_reg    <= 64'd0;
            pending_reg  <= 7'd0;
            wide_reg     <= 1'b0;
            last_reg     <= 1'b0;
            seed_reg     <= 64'd0;
            lane0_reg    <= K0;
            lane1_reg    <= K0;
            lane2_reg    <= K0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            job_reg      <= job_next;
            lane_idx_reg <= lane_idx_next;
            fcnt_reg     <= fcnt_next;
            rd_valid_reg <= rd_valid_next;
            total_reg    <= total_next;
            pending_reg  <= pending_next;
            wide_reg     <= wide_next;
            last_reg     <= last_next;
            seed_reg     <= seed_next;
            lane0_reg    <= lane0_next;
            lane1_reg    <= lane1_next;
            lane2_reg    <= lane2_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        xop_reg  <= xop_next;
        yop_reg  <= yop_next;
        word_reg <= word_next;
        hash_reg <= hash_next;
    end

    // ring: one write port at accept, one registered read port for gathers
    always_ff @(posedge clk)
    begin
        if (accept && byte_present)
            ring_mem[total_reg[5:0]] <= data_byte;
        rdata_reg <= ring_mem[rd_addr];
    end

    assign done       = done_reg;
    assign hash_value = hash_reg;

endmodule

`default_nettype wire

/* rtl/wbs_fold_mul.sv */
`default_nettype none

// 64x64 multiply folded to 64 bits (hi ^ lo), one 32x32 partial product per cycle.
module wbs_fold_mul
    import wbs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] x,
    input  wire logic [63:0] y,
    output logic             done,
    output logic [63:0]      result
);

    logic [63:0]  x_reg, y_reg;
    logic [127:0] acc_reg;
    logic [63:0]  prod_reg;
    logic [1:0]   psh_reg;
    logic [2:0]   cnt_reg, cnt_next;
    logic         run_reg, run_next;
    logic         done_reg, done_next;

    logic [31:0]  xh, yh;
    logic [127:0] addend;

    assign xh = cnt_reg[1] ? x_reg[63:32] : x_reg[31:0];
    assign yh = cnt_reg[0] ? y_reg[63:32] : y_reg[31:0];

    always_comb
    begin
        case (psh_reg)
            2'd0:    addend = {64'd0, prod_reg};
            2'd1:    addend = {32'd0, prod_reg, 32'd0};
            default: addend = {prod_reg, 64'd0};
        endcase
    end

    always_comb
    begin
        run_next  = run_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = 3'd0;
        end
        else if (run_reg)
        begin
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg == 3'd4)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            cnt_reg  <= 3'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= x;
            y_reg   <= y;
            acc_reg <= 128'd0;
        end
        else if (run_reg)
        begin
            if (cnt_reg != 3'd4)
            begin
                prod_reg <= {32'd0, xh} * {32'd0, yh};
                psh_reg  <= {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};
            end
            if (cnt_reg != 3'd0)
                acc_reg <= acc_reg + addend;
        end
    end

    assign done   = done_reg;
    assign result = acc_reg[127:64] ^ acc_reg[63:0];

endmodule

`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;
    import wbs_pkg::*;

    // ------------------------------------------------------------------
    // Clock, reset, block ports
    // ------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [7:0]  data_byte = '0;
    logic        byte_present = 1'b0;
    logic        end_of_message = 1'b0;
    logic        seed_we = 1'b0;
    logic [63:0] hash_seed = '0;
    logic        busy;
    logic        done;
    logic [63:0] hash_value;

    always #2 clk = ~clk;

    wyhash_byte_stream_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .data_byte      (data_byte),
        .byte_present   (byte_present),
        .end_of_message (end_of_message),
        .seed_we        (seed_we),
        .hash_seed      (hash_seed),
        .done           (done),
        .hash_value     (hash_value)
    );

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the hashing state
    // ------------------------------------------------------------------
    logic [63:0] seed_shadow;
    logic [7:0]  msg_ring [64];
    logic [63:0] msg_len;
    logic [63:0] lane_a, lane_b, lane_c;
    int unsigned unabsorbed;
    bit          wide_seen;

    logic [63:0] hashes_due [$];
    int unsigned fail_count = 0;
    int unsigned hashes_seen = 0;
    longint unsigned cycle_count = 0;

    // 64x64 -> 128 product, halves folded by XOR
    function automatic logic [63:0] mul_fold(logic [63:0] x, logic [63:0] y);
        logic [127:0] p;
        p = {64'd0, x} * {64'd0, y};
        return p[127:64] ^ p[63:0];
    endfunction

    // little-endian read of n bytes from the ring, position wraps mod 64
    function automatic logic [63:0] ring_word(logic [63:0] pos, int n);
        logic [63:0] v;
        v = '0;
        for (int k = 0; k < n; k++)
            v |= 64'(msg_ring[6'(pos + 64'(k))]) << (8 * k);
        return v;
    endfunction

    function automatic void reload_lanes();
        lane_a = seed_shadow ^ K0;
        lane_b = lane_a;
        lane_c = lane_a;
    endfunction

    function automatic void clear_msg();
        msg_len = '0;
        unabsorbed = 0;
        wide_seen = 1'b0;
        reload_lanes();
    endfunction

    function automatic logic [63:0] close_hash();
        logic [63:0] s, a, b, off, p;
        int unsigned left;
        s = lane_a;
        if (!wide_seen && msg_len <= 64'd16) begin
            if (msg_len >= 64'd4) begin
                off = (msg_len >> 3) << 2;
                a = (ring_word(0, 4) << 32) | ring_word(off, 4);
                b = (ring_word(msg_len - 4, 4) << 32) | ring_word(msg_len - 4 - off, 4);
            end
            else if (msg_len > 0) begin
                a = (ring_word(0, 1) << 16) | (ring_word(msg_len >> 1, 1) << 8)
                    | ring_word(msg_len - 1, 1);
                b = '0;
            end
            else begin
                a = '0;
                b = '0;
            end
        end
        else begin
            left = unabsorbed;
            if (wide_seen)
                s ^= lane_b ^ lane_c;
            while (left > 16) begin
                p = msg_len - 64'(left);
                s = mul_fold(ring_word(p, 8) ^ K1, ring_word(p + 8, 8) ^ s);
                left -= 16;
            end
            a = ring_word(msg_len - 16, 8);
            b = ring_word(msg_len - 8, 8);
        end
        return mul_fold(K1 ^ msg_len, mul_fold(a ^ K1, b ^ s));
    endfunction

    // advance the predictor by one accepted transaction
    function automatic void predict_item(logic [7:0] d, bit pres, bit last);
        logic [63:0] p;
        if (!pres && !last)
            return;
        if (msg_len == 0 && unabsorbed == 0 && !wide_seen)
            reload_lanes();
        if (pres) begin
            msg_ring[6'(msg_len)] = d;
            msg_len++;
            unabsorbed++;
            if (unabsorbed > WIDE_CHUNK) begin
                p = msg_len - 64'(WIDE_CHUNK + 1);
                lane_a = mul_fold(ring_word(p, 8) ^ K1, ring_word(p + 8, 8) ^ lane_a);
                lane_b = mul_fold(ring_word(p + 16, 8) ^ K2, ring_word(p + 24, 8) ^ lane_b);
                lane_c = mul_fold(ring_word(p + 32, 8) ^ K3, ring_word(p + 40, 8) ^ lane_c);
                unabsorbed -= WIDE_CHUNK;
                wide_seen = 1'b1;
            end
        end
        if (last) begin
            hashes_due.push_back(close_hash());
            clear_msg();
        end
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("tb: mismatch %s: got %h expected %h at cycle %0d",
                 what, got, want, cycle_count);
        fail_count++;
    endtask

    // ------------------------------------------------------------------
    // Result monitor: done is a one-cycle strobe, sampled at the edge
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (rst_n && done) begin
            hashes_seen++;
            if (hashes_due.size() == 0)
                report_mismatch("unexpected hash", hash_value, '0);
            else if (hash_value !== hashes_due[0]) begin
                report_mismatch("hash_value", hash_value, hashes_due[0]);
                void'(hashes_due.pop_front());
            end
            else
                void'(hashes_due.pop_front());
        end
    end

    // run limit: about 1100 items, the message ends and the seed writes
    // all stay well under this bound; past it the bench reports errors
    // and finishes
    localparam longint unsigned CYCLE_LIMIT = 400000;
    always @(posedge clk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    // one transaction: random gap, then start until accepted (start && !busy);
    // start stays high after the accepting edge until the next gap or idle
    task automatic send_item(logic [7:0] d, bit pres, bit last);
        int gap;
        gap = $urandom_range(0, 9);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        data_byte <= d;
        byte_present <= pres;
        end_of_message <= last;
        @(posedge clk);
        while (busy) @(posedge clk);
        predict_item(d, pres, last);
    endtask

    // seed write only with the block idle and no hash outstanding
    task automatic write_seed(logic [63:0] v);
        start <= 1'b0;
        while (hashes_due.size() != 0) @(posedge clk);
        repeat (150) @(posedge clk);
        seed_we <= 1'b1;
        hash_seed <= v;
        @(posedge clk);
        seed_we <= 1'b0;
        seed_shadow = v;
    endtask

    task automatic send_message(int n, bit rand_bytes, logic [7:0] fill);
        for (int i = 0; i < n; i++) begin
            if (n == 0)
                break;
            if ($urandom_range(0, 15) == 0)
                send_item(8'($urandom), 1'b0, 1'b0);   // idle item in the middle
            send_item(rand_bytes ? 8'($urandom) : fill, 1'b1, i == n - 1);
        end
        if (n == 0)
            send_item(8'($urandom), 1'b0, 1'b1);
    endtask

    typedef struct {
        logic [7:0] d;
        bit         pres;
        bit         last;
        bit         known;
        logic [63:0] want;
    } step_row_t;

    // directed rows: bytes of several short messages; no expected hash is typed
    // (known is 0 on every row), so each is left to the predictor
    step_row_t steps [] = '{
        '{8'h00, 1'b0, 1'b0, 1'b0, 64'h0},  // idle item
        '{8'hff, 1'b0, 1'b1, 1'b0, 64'h0},  // empty message
        '{8'h00, 1'b1, 1'b1, 1'b0, 64'h0},  // one zero byte
        '{8'hff, 1'b1, 1'b1, 1'b0, 64'h0},  // one 0xff byte
        '{8'h01, 1'b1, 1'b0, 1'b0, 64'h0},
        '{8'h80, 1'b1, 1'b0, 1'b0, 64'h0},
        '{8'h7f, 1'b1, 1'b1, 1'b0, 64'h0},  // three bytes
        '{8'haa, 1'b1, 1'b0, 1'b0, 64'h0},
        '{8'h55, 1'b1, 1'b0, 1'b0, 64'h0},
        '{8'h00, 1'b0, 1'b0, 1'b0, 64'h0},  // idle inside a message
        '{8'hff, 1'b1, 1'b0, 1'b0, 64'h0},
        '{8'h00, 1'b1, 1'b0, 1'b0, 64'h0},
        '{8'h00, 1'b0, 1'b1, 1'b0, 64'h0}   // end marker after four bytes
    };

    logic [63:0] seeds [4] = '{64'h0, 64'hffff_ffff_ffff_ffff,
                               64'h0123_4567_89ab_cdef, 64'h8000_0000_0000_0001};

    // short reads, one 16-byte fold plus tail, one wide absorb, wide absorb plus two 16-byte folds
    int boundary_lens [6] = '{3, 4, 16, 17, 49, 96};

    initial begin
        seed_shadow = '0;
        foreach (msg_ring[i]) msg_ring[i] = '0;
        clear_msg();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (steps[i]) begin
            send_item(steps[i].d, steps[i].pres, steps[i].last);
            if (steps[i].known && hashes_due.size() != 0)
                hashes_due[$] = steps[i].want;
        end

        // length boundaries on every seed
        foreach (seeds[s]) begin
            write_seed(seeds[s]);
            foreach (boundary_lens[k])
                send_message(boundary_lens[k], 1'b1, 8'h00);
        end

        // random messages; seed rewritten now and then
        for (int budget = 260; budget > 0;) begin
            int n;
            if ($urandom_range(0, 7) == 0)
                write_seed({$urandom, $urandom});
            case ($urandom_range(0, 3))
                0: n = $urandom_range(0, 16);
                1: n = $urandom_range(17, 48);
                2: n = $urandom_range(49, 120);
                default: n = $urandom_range(0, 5);
            endcase
            send_message(n, $urandom_range(0, 5) != 0, ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00);
            budget -= (n == 0) ? 1 : n;
        end

        start <= 1'b0;
        while (hashes_due.size() != 0) @(posedge clk);
        repeat (150) @(posedge clk);
        if (fail_count == 0 && hashes_due.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

/* wyhash_byte_stream_top.f */
rtl/wbs_pkg.sv
rtl/wbs_fold_mul.sv
rtl/wyhash_byte_stream_top.sv
test/tb.sv
